@@ rtl/vhba_pkg.sv @@
package vhba_pkg;

    localparam int NUM_STAGES = 30;
    localparam int WORD_W     = 64;
    localparam int NORM_MSB   = 59;
    localparam int ANGLE_W    = 32;

    typedef logic signed [WORD_W-1:0]  vhba_word_t;
    typedef logic signed [ANGLE_W-1:0] vhba_angle_t;

    // Per-request flags that ride along the datapath for the final quadrant mapping
    typedef struct packed {
        logic vert;
        logic dx_neg;
        logic dy_neg;
        logic dy_pos;
    } vhba_side_t;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    localparam logic [ANGLE_W-1:0] ATAN_TURN [NUM_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

endpackage

@@ rtl/vector_heading_binary_angle.sv @@
// Pipeline from request to result: one stage for the differences, one per normalize step,
// 30 CORDIC stages, two to finish.
// Throughput: one request per cycle; every stage holds while a finished result is stalled.
// Reset clears all valid bits asynchronously; the datapath registers are not reset.
module vector_heading_binary_angle #(
    parameter int COORD_WIDTH   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] from_x,
    input  logic signed [COORD_WIDTH-1:0] from_y,
    input  logic signed [COORD_WIDTH-1:0] to_x,
    input  logic signed [COORD_WIDTH-1:0] to_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   heading
);
    import vhba_pkg::*;

    localparam int NORM_STEPS = $clog2(COORD_WIDTH + 1);

    logic        advance;
    logic        nv   [NORM_STEPS+1];
    vhba_word_t  na   [NORM_STEPS+1];
    vhba_word_t  nb   [NORM_STEPS+1];
    vhba_side_t  ns   [NORM_STEPS+1];
    logic        cv   [NUM_STAGES+1];
    vhba_word_t  cx   [NUM_STAGES+1];
    vhba_word_t  cy   [NUM_STAGES+1];
    vhba_angle_t cz   [NUM_STAGES+1];
    vhba_side_t  cs   [NUM_STAGES+1];
    logic        res_valid;

    // advance the whole pipe unless a finished result is held
    assign advance  = !res_valid || !out_stall;
    assign in_stall = !advance;

    vhba_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_valid),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .out_valid (nv[0]),
        .mag_a     (na[0]),
        .mag_b     (nb[0]),
        .side      (ns[0])
    );

    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        vhba_norm_step #(
            .SHIFT (1 << (NORM_STEPS - 1 - j))
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (nv[j]),
            .in_a      (na[j]),
            .in_b      (nb[j]),
            .in_side   (ns[j]),
            .out_valid (nv[j+1]),
            .out_a     (na[j+1]),
            .out_b     (nb[j+1]),
            .out_side  (ns[j+1])
        );
    end

    assign cv[0] = nv[NORM_STEPS];
    assign cx[0] = na[NORM_STEPS];
    assign cy[0] = nb[NORM_STEPS];
    assign cz[0] = '0;
    assign cs[0] = ns[NORM_STEPS];

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_cordic
        vhba_cordic_stage #(
            .IDX (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (cv[i]),
            .in_x      (cx[i]),
            .in_y      (cy[i]),
            .in_z      (cz[i]),
            .in_side   (cs[i]),
            .out_valid (cv[i+1]),
            .out_x     (cx[i+1]),
            .out_y     (cy[i+1]),
            .out_z     (cz[i+1]),
            .out_side  (cs[i+1])
        );
    end

    // final x holds the magnitude scaled by the CORDIC gain and is unused; the angle is in z
    vhba_finish #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (cv[NUM_STAGES]),
        .in_z      (cz[NUM_STAGES]),
        .in_side   (cs[NUM_STAGES]),
        .out_valid (res_valid),
        .heading   (heading)
    );

    assign out_valid = res_valid;

endmodule

@@ rtl/vhba_prep.sv @@
module vhba_prep #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] from_x,
    input  logic signed [COORD_WIDTH-1:0] from_y,
    input  logic signed [COORD_WIDTH-1:0] to_x,
    input  logic signed [COORD_WIDTH-1:0] to_y,
    output logic                          out_valid,
    output vhba_pkg::vhba_word_t          mag_a,
    output vhba_pkg::vhba_word_t          mag_b,
    output vhba_pkg::vhba_side_t          side
);
    import vhba_pkg::*;

    // place a full-scale magnitude of 2^COORD_WIDTH at bit NORM_MSB
    localparam int BASE = NORM_MSB - COORD_WIDTH;

    logic signed [COORD_WIDTH:0] dx;
    logic signed [COORD_WIDTH:0] dy;
    logic [COORD_WIDTH:0]        ax;
    logic [COORD_WIDTH:0]        ay;
    logic                        valid_reg;
    vhba_word_t                  a_reg;
    vhba_word_t                  a_next;
    vhba_word_t                  b_reg;
    vhba_word_t                  b_next;
    vhba_side_t                  side_reg;
    vhba_side_t                  side_next;

    always_comb
    begin
        dx = (COORD_WIDTH+1)'(to_x) - (COORD_WIDTH+1)'(from_x);
        dy = (COORD_WIDTH+1)'(to_y) - (COORD_WIDTH+1)'(from_y);
        ax = dx[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dx) : (COORD_WIDTH+1)'(dx);
        ay = dy[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dy) : (COORD_WIDTH+1)'(dy);
        a_next = vhba_word_t'(WORD_W'(ax) << BASE);
        b_next = vhba_word_t'(WORD_W'(ay) << BASE);
        side_next.vert   = (dx == '0);
        side_next.dx_neg = dx[COORD_WIDTH];
        side_next.dy_neg = dy[COORD_WIDTH];
        side_next.dy_pos = !dy[COORD_WIDTH] && (dy != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign mag_a     = a_reg;
    assign mag_b     = b_reg;
    assign side      = side_reg;

endmodule

@@ rtl/vhba_norm_step.sv @@
module vhba_norm_step #(
    parameter int SHIFT = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  vhba_pkg::vhba_word_t in_a,
    input  vhba_pkg::vhba_word_t in_b,
    input  vhba_pkg::vhba_side_t in_side,
    output logic                 out_valid,
    output vhba_pkg::vhba_word_t out_a,
    output vhba_pkg::vhba_word_t out_b,
    output vhba_pkg::vhba_side_t out_side
);
    import vhba_pkg::*;

    vhba_word_t mag_or;
    logic       do_shift;
    logic       valid_reg;
    vhba_word_t a_reg;
    vhba_word_t a_next;
    vhba_word_t b_reg;
    vhba_word_t b_next;
    vhba_side_t side_reg;

    // the larger magnitude leads wherever the OR of both leads
    always_comb
    begin
        mag_or   = in_a | in_b;
        do_shift = (mag_or[NORM_MSB -: SHIFT] == '0);
        a_next   = do_shift ? (in_a <<< SHIFT) : in_a;
        b_next   = do_shift ? (in_b <<< SHIFT) : in_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/vhba_cordic_stage.sv @@
module vhba_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  vhba_pkg::vhba_word_t  in_x,
    input  vhba_pkg::vhba_word_t  in_y,
    input  vhba_pkg::vhba_angle_t in_z,
    input  vhba_pkg::vhba_side_t  in_side,
    output logic                  out_valid,
    output vhba_pkg::vhba_word_t  out_x,
    output vhba_pkg::vhba_word_t  out_y,
    output vhba_pkg::vhba_angle_t out_z,
    output vhba_pkg::vhba_side_t  out_side
);
    import vhba_pkg::*;

    localparam vhba_angle_t STEP_ANGLE = vhba_angle_t'(ATAN_TURN[IDX]);

    vhba_word_t  x_sh;
    vhba_word_t  y_sh;
    logic        valid_reg;
    vhba_word_t  x_reg;
    vhba_word_t  x_next;
    vhba_word_t  y_reg;
    vhba_word_t  y_next;
    vhba_angle_t z_reg;
    vhba_angle_t z_next;
    vhba_side_t  side_reg;

    // rotate toward y = 0; arithmetic shifts floor
    always_comb
    begin
        x_sh = in_x >>> IDX;
        y_sh = in_y >>> IDX;
        if (!in_y[WORD_W-1])
        begin
            x_next = in_x + y_sh;
            y_next = in_y - x_sh;
            z_next = in_z + STEP_ANGLE;
        end
        else
        begin
            x_next = in_x - y_sh;
            y_next = in_y + x_sh;
            z_next = in_z - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/vhba_finish.sv @@
module vhba_finish #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  vhba_pkg::vhba_angle_t in_z,
    input  vhba_pkg::vhba_side_t  in_side,
    output logic                  out_valid,
    output logic [15:0]           heading
);
    import vhba_pkg::*;

    localparam int HW = 8 + FRACTION_BITS;
    localparam logic [ANGLE_W:0]   RND_BIAS  = (ANGLE_W+1)'(1) << (23 - FRACTION_BITS);
    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h80000000;
    localparam logic [ANGLE_W-2:0] QUARTER   = (ANGLE_W-1)'(1) << (ANGLE_W - 2);
    localparam logic [HW-1:0]      HEAD_UP   = HW'(64) << FRACTION_BITS;
    localparam logic [HW-1:0]      HEAD_DOWN = HW'(192) << FRACTION_BITS;

    logic [ANGLE_W-2:0] phi;
    logic [ANGLE_W:0]   rnd_sum;
    logic [HW-1:0]      rnd_head;
    logic               mid_valid_reg;
    logic [ANGLE_W-1:0] ang_reg;
    logic [ANGLE_W-1:0] ang_next;
    vhba_side_t         side_reg;
    logic               valid_reg;
    logic [15:0]        head_reg;
    logic [15:0]        head_next;

    // clamp to a quarter turn, then map into the right quadrant
    always_comb
    begin
        if (in_z[ANGLE_W-1])
        begin
            phi = '0;
        end
        else if (in_z > vhba_angle_t'(QUARTER))
        begin
            phi = QUARTER;
        end
        else
        begin
            phi = in_z[ANGLE_W-2:0];
        end

        if (!in_side.dx_neg && in_side.dy_neg)
        begin
            ang_next = ANGLE_W'(phi);
        end
        else if (in_side.dx_neg && in_side.dy_neg)
        begin
            ang_next = HALF_TURN - ANGLE_W'(phi);
        end
        else if (in_side.dx_neg)
        begin
            ang_next = HALF_TURN + ANGLE_W'(phi);
        end
        else
        begin
            ang_next = '0 - ANGLE_W'(phi);
        end
    end

    // round half up, wrap at one turn; a vertical vector takes the fixed up or down heading
    always_comb
    begin
        rnd_sum  = {1'b0, ang_reg} + RND_BIAS;
        rnd_head = HW'(rnd_sum >> (24 - FRACTION_BITS));
        if (side_reg.vert)
        begin
            head_next = 16'(side_reg.dy_pos ? HEAD_DOWN : HEAD_UP);
        end
        else
        begin
            head_next = 16'(rnd_head);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= in_valid;
            valid_reg     <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg  <= ang_next;
            side_reg <= in_side;
            head_reg <= head_next;
        end
    end

    assign out_valid = valid_reg;
    assign heading   = head_reg;

endmodule

@@ tb/vector_heading_binary_angle_tb.sv @@
`timescale 1ns / 1ps

module vector_heading_binary_angle_tb;

    localparam int FRAC_BITS   = 8;
    localparam int CORDIC_ITER = 30;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLD_CYCLES = 200;

    // atan(2^-i) in 2^-32 turn, rounded to nearest
    localparam logic [31:0] TURN_ATAN [CORDIC_ITER] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
    } point_pair_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic signed [15:0] from_x    = '0;
    logic signed [15:0] from_y    = '0;
    logic signed [15:0] to_x      = '0;
    logic signed [15:0] to_y      = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        heading;

    point_pair_t pending_requests[$];
    logic [15:0] expected_headings[$];
    point_pair_t next_req;

    int  n_total    = 0;
    int  n_issued   = 0;
    int  n_accepted = 0;
    int  n_errors   = 0;
    int  send_gap   = 0;
    int  stall_left = 0;
    logic hold_off  = 1'b0;

    vector_heading_binary_angle dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .heading   (heading)
    );

    function automatic logic [15:0] heading_of(input logic signed [15:0] fx,
                                               input logic signed [15:0] fy,
                                               input logic signed [15:0] tx,
                                               input logic signed [15:0] ty);
        longint             dx;
        longint             dy;
        longint             z;
        logic [63:0]        mag_x;
        logic [63:0]        mag_y;
        logic [63:0]        peak;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic [31:0]        phi;
        logic [31:0]        ang;
        logic [63:0]        wide;
        dx = longint'(tx) - longint'(fx);
        dy = longint'(ty) - longint'(fy);
        if (dx == 0)
            return (dy <= 0) ? 16'(64 << FRAC_BITS) : 16'(192 << FRAC_BITS);
        mag_x = (dx < 0) ? 64'(-dx) : 64'(dx);
        mag_y = (dy < 0) ? 64'(-dy) : 64'(dy);
        peak  = (mag_x > mag_y) ? mag_x : mag_y;
        // normalize so the larger magnitude reaches bit 59
        while (peak < (64'd1 << 59))
        begin
            peak  = peak << 1;
            mag_x = mag_x << 1;
            mag_y = mag_y << 1;
        end
        cx = signed'(mag_x);
        cy = signed'(mag_y);
        z  = 0;
        for (int i = 0; i < CORDIC_ITER; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                z  = z + longint'(TURN_ATAN[i]);
            end
            else
            begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                z  = z - longint'(TURN_ATAN[i]);
            end
            cx = nx;
            cy = ny;
        end
        if (z < 0)
            z = 0;
        if (z > (longint'(1) << 30))
            z = longint'(1) << 30;
        phi = 32'(z);
        if (dx > 0 && dy < 0)
            ang = phi;
        else if (dx < 0 && dy < 0)
            ang = 32'h8000_0000 - phi;
        else if (dx < 0)
            ang = 32'h8000_0000 + phi;
        else
            ang = 32'd0 - phi;
        wide = 64'(ang) + (64'd1 << (23 - FRAC_BITS));
        wide = (wide >> (24 - FRAC_BITS)) & ((64'd1 << (8 + FRAC_BITS)) - 64'd1);
        return wide[15:0];
    endfunction

    // no idling in a middle stretch and in the tail of the run
    function automatic bit idling_allowed(input int idx);
        return !(idx >= 300 && idx < 400) && (idx < n_total - 100);
    endfunction

    task automatic push_request(input int fx, input int fy, input int tx, input int ty);
        point_pair_t r;
        r.fx = 16'(fx);
        r.fy = 16'(fy);
        r.tx = 16'(tx);
        r.ty = 16'(ty);
        pending_requests.push_back(r);
    endtask

    task automatic push_random_request();
        int fx;
        int fy;
        int tx;
        int ty;
        int pick;
        int d;
        int corner [5];
        corner = '{-32768, -1, 0, 1, 32767};
        fx   = int'(16'($urandom));
        fy   = int'(16'($urandom));
        tx   = int'(16'($urandom));
        ty   = int'(16'($urandom));
        pick = $urandom_range(0, 9);
        case (pick)
            4, 5:
            begin
                tx = fx + $urandom_range(0, 16) - 8;
                ty = fy + $urandom_range(0, 16) - 8;
            end
            6:
                tx = fx;
            7:
                ty = fy;
            8:
            begin
                fx = corner[$urandom_range(0, 4)];
                fy = corner[$urandom_range(0, 4)];
                tx = corner[$urandom_range(0, 4)];
                ty = corner[$urandom_range(0, 4)];
            end
            9:
            begin
                d  = $urandom_range(1, 20000);
                tx = fx + (($urandom_range(0, 1) == 1) ? d : -d);
                ty = fy + (($urandom_range(0, 1) == 1) ? d : -d);
            end
            default:
            begin
            end
        endcase
        push_request(fx, fy, tx, ty);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender: hold the request until accepted, then advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_headings.push_back(heading_of(from_x, from_y, to_x, to_y));
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    from_x   <= next_req.fx;
                    from_y   <= next_req.fy;
                    to_x     <= next_req.tx;
                    to_y     <= next_req.ty;
                    n_issued <= n_issued + 1;
                    if (idling_allowed(n_issued) && $urandom_range(0, 99) < 20)
                        send_gap <= $urandom_range(1, 6);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_off)
        begin
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling_allowed(n_issued) && $urandom_range(0, 99) < 15)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_headings.size() == 0)
            begin
                $error("heading: expected none, got %0d", heading);
                n_errors <= n_errors + 1;
            end
            else if (heading !== expected_headings[0])
            begin
                $error("heading: expected %0d, got %0d", expected_headings[0], heading);
                n_errors <= n_errors + 1;
                void'(expected_headings.pop_front());
            end
            else
            begin
                void'(expected_headings.pop_front());
            end
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin
        wait (rst_n === 1'b1);
        while (n_accepted < 150)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[vector_heading_binary_angle] ERROR");
        $finish;
    end

    initial
    begin
        // zero vector, at the origin and at the far corner
        push_request(0, 0, 0, 0);
        push_request(-32768, -32768, -32768, -32768);
        // vertical up and down over the full span, and a one-unit vertical step
        push_request(-32768, 32767, -32768, -32768);
        push_request(32767, -32768, 32767, 32767);
        push_request(5, 0, 5, 1);
        // horizontal right and left
        push_request(-32768, 0, 32767, 0);
        push_request(32767, 0, -32768, 0);
        push_request(0, 0, 1, 0);
        push_request(0, 0, -1, 0);
        // diagonals in all four quadrants
        push_request(0, 0, 100, -100);
        push_request(0, 0, -100, -100);
        push_request(0, 0, -100, 100);
        push_request(0, 0, 100, 100);
        // just below a full turn: rounds up and wraps to zero
        push_request(-32768, 0, 32767, 1);
        push_request(0, 0, 32767, 1);
        // close to straight up and straight down
        push_request(0, 32767, 1, -32768);
        push_request(0, 32767, -1, -32768);
        push_request(0, -32768, 1, 32767);
        push_request(0, -32768, -1, 32767);
        // extreme corners, and a one-unit diagonal
        push_request(-32768, -32768, 32767, 32767);
        push_request(32767, 32767, -32768, -32768);
        push_request(-32768, 32767, 32767, -32768);
        push_request(32767, -32768, -32768, 32767);
        push_request(0, 0, 1, -1);
        for (int i = 0; i < 700; i++)
            push_random_request();
        n_total = pending_requests.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total || expected_headings.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("[vector_heading_binary_angle] OK");
        else
            $display("[vector_heading_binary_angle] ERROR");
        $finish;
    end

endmodule
